// ----- hdl/longest_zigzag_subsequence_unit_macros.svh -----
// Assertion macros shared by the checker
`ifndef LONGEST_ZIGZAG_SUBSEQUENCE_UNIT_MACROS_SVH
`define LONGEST_ZIGZAG_SUBSEQUENCE_UNIT_MACROS_SVH
`define LZS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define LZS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ----- hdl/lzs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lzs_pkg;
   localparam int SampleWidth = 32;

   typedef struct packed {
      logic [SampleWidth-1:0] sample;
      logic                   final_item;
   } req_payload_type;

   typedef struct packed {
      logic [SampleWidth-1:0] chosen;
      logic                   run_end;
   } rsp_payload_type;

   typedef enum logic [6:0] {
      ST_LOAD   = 7'b0000001,
      ST_OUTER  = 7'b0000010,
      ST_INNER  = 7'b0000100,
      ST_WRITE  = 7'b0001000,
      ST_TRACE  = 7'b0010000,
      ST_FETCH  = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic start_cur;
      logic step_prev;
      logic write_cur;
      logic start_trace;
      logic fetch;
      logic follow;
   } cmd_type;

   typedef struct packed {
      logic inner_done;
      logic outer_done;
      logic last_elem;
   } status_type;
endpackage
`default_nettype wire

// ----- hdl/lzs_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lzs_datapath import lzs_pkg::*; #(
   parameter int MAX_ITEMS = 64
) (
   input  wire logic            clock,
   input  wire cmd_type         cmd,
   input  wire req_payload_type req_data,
   output status_type           status,
   output rsp_payload_type      rsp_data_ff
);
   localparam int IW = (MAX_ITEMS > 2) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = $clog2(MAX_ITEMS + 1);

   logic [SampleWidth-1:0] value_mem [MAX_ITEMS];
   logic [CW-1:0]          up_len_mem [MAX_ITEMS];
   logic [CW-1:0]          dn_len_mem [MAX_ITEMS];
   logic [IW-1:0]          up_lnk_mem [MAX_ITEMS];
   logic [IW-1:0]          dn_lnk_mem [MAX_ITEMS];

   logic [CW-1:0] count_ff, n_ff, cur_ff, prev_ff, best_len_ff, left_ff;
   logic [IW-1:0] best_end_ff, pos_ff;
   logic [SampleWidth-1:0] vc_ff, vp_ff;
   logic [CW-1:0] ulen_ff, dlen_ff, p_ulen_ff, p_dlen_ff;
   logic [IW-1:0] ulnk_ff, dlnk_ff;
   logic          falling_ff, pvalid_ff;
   logic [CW-1:0] cand_up, cand_dn;
   logic          lt, gt;
   logic [IW-1:0] rd_addr;

   function automatic logic [IW-1:0] vidx(input logic [CW-1:0] n, input logic [CW-1:0] p);
      logic [CW-1:0] t;
      t = n - CW'(1) - p;
      if (t >= CW'(MAX_ITEMS)) t = '0;
      return t[IW-1:0];
   endfunction

   function automatic logic [IW-1:0] guard(input logic [IW-1:0] p, input logic [CW-1:0] n);
      return (CW'(p) >= n) ? '0 : p;
   endfunction

   assign lt = $signed(vp_ff) < $signed(vc_ff);
   assign gt = $signed(vp_ff) > $signed(vc_ff);
   assign cand_up = p_dlen_ff + CW'(1);
   assign cand_dn = p_ulen_ff + CW'(1);

   assign rd_addr = cmd.start_cur ? vidx(n_ff, cur_ff)
                  : cmd.fetch     ? vidx(n_ff, CW'(pos_ff))
                  :                 vidx(n_ff, prev_ff);

   assign status.inner_done = !pvalid_ff && (prev_ff >= cur_ff);
   assign status.outer_done = (cur_ff >= n_ff);
   assign status.last_elem  = (left_ff == CW'(1));

   always_ff @(posedge clock) begin
      if (cmd.load && count_ff < CW'(MAX_ITEMS)) begin
         value_mem[count_ff[IW-1:0]] <= req_data.sample;
      end
      if (cmd.clear) begin
         count_ff    <= '0;
         n_ff        <= (cmd.load && count_ff < CW'(MAX_ITEMS)) ? count_ff + CW'(1) : count_ff;
         cur_ff      <= '0;
         best_len_ff <= CW'(1);
         best_end_ff <= IW'(1);
      end else if (cmd.load && count_ff < CW'(MAX_ITEMS)) begin
         count_ff <= count_ff + CW'(1);
      end
      pvalid_ff <= cmd.step_prev && (prev_ff < cur_ff);
      if (cmd.start_cur) begin
         vc_ff   <= value_mem[rd_addr];
         ulen_ff <= CW'(1);
         dlen_ff <= CW'(1);
         ulnk_ff <= '0;
         dlnk_ff <= '0;
         prev_ff <= '0;
      end
      if (cmd.step_prev) begin
         if (pvalid_ff) begin
            if (lt && cand_up >= ulen_ff) begin
               ulnk_ff <= pos_ff;
               ulen_ff <= cand_up;
               if (best_len_ff <= cand_up) begin
                  best_len_ff <= cand_up;
                  best_end_ff <= cur_ff[IW-1:0];
               end
            end else if (gt && cand_dn >= dlen_ff) begin
               dlnk_ff <= pos_ff;
               dlen_ff <= cand_dn;
               if (best_len_ff <= cand_dn) begin
                  best_len_ff <= cand_dn;
                  best_end_ff <= cur_ff[IW-1:0];
               end
            end
         end
         if (prev_ff < cur_ff) begin
            vp_ff     <= value_mem[rd_addr];
            p_ulen_ff <= up_len_mem[prev_ff[IW-1:0]];
            p_dlen_ff <= dn_len_mem[prev_ff[IW-1:0]];
            pos_ff    <= prev_ff[IW-1:0];
            prev_ff   <= prev_ff + CW'(1);
         end
      end
      if (cmd.write_cur) begin
         up_len_mem[cur_ff[IW-1:0]] <= ulen_ff;
         dn_len_mem[cur_ff[IW-1:0]] <= dlen_ff;
         up_lnk_mem[cur_ff[IW-1:0]] <= ulnk_ff;
         dn_lnk_mem[cur_ff[IW-1:0]] <= dlnk_ff;
         cur_ff <= cur_ff + CW'(1);
      end
      if (cmd.start_trace) begin
         pos_ff     <= (n_ff <= CW'(1)) ? '0 : guard(best_end_ff, n_ff);
         left_ff    <= (n_ff <= CW'(1)) ? CW'(1) : best_len_ff;
         falling_ff <= dn_len_mem[guard(best_end_ff, n_ff)] == best_len_ff;
      end
      if (cmd.fetch) begin
         rsp_data_ff.chosen  <= value_mem[rd_addr];
         rsp_data_ff.run_end <= (left_ff == CW'(1));
         ulnk_ff <= up_lnk_mem[pos_ff];
         dlnk_ff <= dn_lnk_mem[pos_ff];
      end
      if (cmd.follow) begin
         pos_ff     <= guard(falling_ff ? dlnk_ff : ulnk_ff, n_ff);
         falling_ff <= !falling_ff;
         left_ff    <= left_ff - CW'(1);
      end
   end
endmodule
`default_nettype wire

// ----- hdl/lzs_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lzs_controller import lzs_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_final,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   input  wire status_type status,
   output cmd_type         cmd
);
   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_LOAD);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd         = '0;
      state_in    = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            cmd.load = accept;
            if (accept && req_final) begin
               cmd.clear = 1'b1;
               state_in  = ST_OUTER;
            end
         end
         ST_OUTER: begin
            if (status.outer_done) begin
               cmd.start_trace = 1'b1;
               state_in        = ST_FETCH;
            end else begin
               cmd.start_cur = 1'b1;
               state_in      = ST_INNER;
            end
         end
         ST_INNER: begin
            cmd.step_prev = 1'b1;
            if (status.inner_done) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.write_cur = 1'b1;
            state_in      = ST_OUTER;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               if (status.last_elem) begin
                  state_in = ST_LOAD;
               end else begin
                  cmd.follow = 1'b1;
                  state_in   = ST_TRACE;
               end
            end
         end
         ST_TRACE: state_in = ST_FETCH;
         default:  state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_LOAD;
      else       state_ff <= state_in;
   end
endmodule
`default_nettype wire

// ----- hdl/longest_zigzag_subsequence_unit.sv -----
// Sequence: samples load while idle; after the final transaction the unit fills the length
// tables, then traces back from the best end, emitting one result per fetched position.
// Throughput: one sample per cycle while loading; the final transaction blocks input
// until the last result is taken; the compute loop visits every earlier position once.
// Reset: synchronous, active high; returns to the empty load state.
`timescale 1ns / 1ps
`default_nettype none
module longest_zigzag_subsequence_unit import lzs_pkg::*; #(
   parameter int MAX_ITEMS = 64
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_data
);
   cmd_type    cmd;
   status_type status;
   logic       ld_clear;
   cmd_type    dp_cmd;

   assign ld_clear = reset;
   always_comb begin
      dp_cmd = cmd;
      if (ld_clear) dp_cmd.clear = 1'b1;
   end

   lzs_controller u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_final(req_data.final_item),
      .rsp_valid, .rsp_stall, .status, .cmd
   );

   lzs_datapath #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
      .clock, .cmd(dp_cmd), .req_data, .status, .rsp_data_ff(rsp_data)
   );
endmodule
`default_nettype wire

// ----- hdl/lzs_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "longest_zigzag_subsequence_unit_macros.svh"
module lzs_checker import lzs_pkg::*; (
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_stall,
   input wire req_payload_type req_data,
   input wire logic            rsp_valid,
   input wire logic            rsp_stall,
   input wire rsp_payload_type rsp_data
);
   logic final_acc;

   assign final_acc = req_valid && !req_stall && req_data.final_item;

   `LZS_ASSERT_IMPL(a_excl, clock, reset, rsp_valid, req_stall, "input open while emitting")
   `LZS_ASSERT_NEXT(a_final, clock, reset, final_acc, req_stall, "final transaction not blocking")
   `LZS_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")
endmodule
bind longest_zigzag_subsequence_unit lzs_checker u_chk (.*);
`default_nettype wire

// ----- dv/longest_zigzag_subsequence_checker.sv -----
`timescale 1ns / 1ps
module longest_zigzag_subsequence_checker import lzs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  req_payload_type req_data,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  rsp_payload_type rsp_data,
   output int              fail_count,
   output int              pending
);
   localparam int Depth = 64;

   logic [SampleWidth-1:0] held_samples [Depth];
   int                     held_count;
   rsp_payload_type        awaited_picks [$];
   int                     up_len [Depth];
   int                     down_len [Depth];
   int                     up_back [Depth];
   int                     down_back [Depth];

   function automatic logic signed [SampleWidth-1:0] rev_at(int n, int p);
      int idx;
      idx = n - 1 - p;
      if (idx < 0 || idx >= Depth) idx = 0;
      return $signed(held_samples[idx]);
   endfunction

   task automatic predict_zigzag(input int n);
      int best_len, best_pos, pos, cand;
      logic falling;
      rsp_payload_type pick;
      best_len = 1;
      best_pos = 1;
      for (int cur = 0; cur < n; cur++) begin
         up_len[cur] = 1;
         down_len[cur] = 1;
         up_back[cur] = 0;
         down_back[cur] = 0;
         for (int prv = 0; prv < cur; prv++) begin
            if (rev_at(n, prv) < rev_at(n, cur)) begin
               cand = down_len[prv] + 1;
               if (cand >= up_len[cur]) begin
                  up_back[cur] = prv;
                  up_len[cur] = cand;
                  if (best_len <= cand) begin
                     best_len = cand;
                     best_pos = cur;
                  end
               end
            end else if (rev_at(n, prv) > rev_at(n, cur)) begin
               cand = up_len[prv] + 1;
               if (cand >= down_len[cur]) begin
                  down_back[cur] = prv;
                  down_len[cur] = cand;
                  if (best_len <= cand) begin
                     best_len = cand;
                     best_pos = cur;
                  end
               end
            end
         end
      end
      pos = (best_pos >= n) ? 0 : best_pos;
      falling = (down_len[pos] == best_len);
      for (int i = 0; i < best_len; i++) begin
         pick.chosen = rev_at(n, pos);
         pick.run_end = (i + 1 == best_len);
         awaited_picks.push_back(pick);
         if (i + 1 < best_len) begin
            pos = falling ? down_back[pos] : up_back[pos];
            if (pos >= n) pos = 0;
            falling = !falling;
         end
      end
   endtask

   assign pending = awaited_picks.size();

   always @(posedge clock) begin
      rsp_payload_type want;
      int n;
      if (reset) begin
         held_count <= 0;
         fail_count <= 0;
         awaited_picks.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_picks.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected transaction: chosen=%0d run_end=%0b",
                           $signed(rsp_data.chosen), rsp_data.run_end);
               fail_count <= fail_count + 1;
            end else begin
               want = awaited_picks.pop_front();
               if (want.chosen !== rsp_data.chosen || want.run_end !== rsp_data.run_end) begin
                  if (fail_count < 10)
                     $display("mismatch: expected chosen=%0d run_end=%0b, got chosen=%0d run_end=%0b",
                              $signed(want.chosen), want.run_end,
                              $signed(rsp_data.chosen), rsp_data.run_end);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            n = held_count;
            if (n < Depth) begin
               held_samples[n] = req_data.sample;
               n++;
            end
            if (req_data.final_item) begin
               if (n <= 1) begin
                  want.chosen = held_samples[0];
                  want.run_end = 1'b1;
                  awaited_picks.push_back(want);
               end else begin
                  predict_zigzag(n);
               end
               n = 0;
            end
            held_count <= n;
         end
      end
   end
endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
module tb;
   import lzs_pkg::*;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;
   int              fail_count;
   int              pending;

   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   logic            hold_request = 1'b0;
   int              hold_left = 0;
   int              items_sent = 0;
   int              quiet_cycles = 0;

   longest_zigzag_subsequence_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   longest_zigzag_subsequence_checker zigzag_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = 400;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= 20000) begin
         $display("longest_zigzag_subsequence_unit regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_sample(input logic [31:0] value, input logic last);
      logic stalled;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(5, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{sample: value, final_item: last};
      forever begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
         if (!stalled) break;
      end
      items_sent++;
   endtask

   task automatic send_zigzag_run(input int len, input int flavour);
      logic [31:0] value;
      for (int i = 0; i < len; i++) begin
         case (flavour)
            0: value = $urandom();
            1: value = $urandom_range(6) - 3;
            2: value = ($urandom_range(1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
            default: value = ((i % 2) != 0) ? $urandom_range(1000) : -$urandom_range(1000);
         endcase
         send_sample(value, i == len - 1);
      end
   endtask

   task automatic drain_results;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic random_phase(input int goal);
      int len;
      while (items_sent < goal) begin
         len = ($urandom_range(19) == 0) ? 64 : $urandom_range(12, 1);
         send_zigzag_run(len, $urandom_range(3));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_sample(32'h8000_0000, 1'b1);
      send_sample(32'h7fff_ffff, 1'b1);
      send_sample(32'd5, 1'b0);
      send_sample(32'd5, 1'b1);
      send_sample(-32'sd7, 1'b0);
      send_sample(-32'sd7, 1'b0);
      send_sample(-32'sd7, 1'b1);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h7fff_ffff, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h7fff_ffff, 1'b1);
      send_sample(32'd1, 1'b0);
      send_sample(32'd2, 1'b0);
      send_sample(32'd3, 1'b0);
      send_sample(32'd2, 1'b0);
      send_sample(32'd1, 1'b1);
      send_sample(32'hffff_ffff, 1'b0);
      send_sample(32'h0000_0000, 1'b1);
      drain_results();

      send_zigzag_run(70, 0);
      drain_results();

      send_idle_pct = 9;
      recv_idle_pct = 74;
      random_phase(150);
      drain_results();

      hold_request = 1'b1;
      send_zigzag_run(10, 3);
      send_zigzag_run(6, 0);
      drain_results();

      send_idle_pct = 74;
      recv_idle_pct = 9;
      random_phase(270);
      drain_results();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(360);
      drain_results();

      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("longest_zigzag_subsequence_unit regression: pass");
      end else begin
         $display("longest_zigzag_subsequence_unit regression: fail");
      end
      $finish;
   end
endmodule
